>>> design/aarm_pkg.sv
// Shared types and constants for the axis-angle rotation matrix block.
// Depends on nothing; the front, back and top files refer to it by scoped names.
package aarm_pkg;

  localparam int AtanLen = 24;
  localparam int AngleLimit = 25736;
  localparam int CordW = 34;
  localparam int ScW = 20;
  localparam int OutW = 24;
  localparam logic signed [CordW-1:0] HalfPiQ30 = 34'sd1686629713;
  localparam logic signed [CordW-1:0] PiQ30 = 34'sd3373259426;
  localparam logic signed [CordW-1:0] GainQ30 = 34'sd652032874;
  localparam logic [1:0] LastRow = 2'd3;

  typedef struct packed {
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [15:0] angle;
  } in_t;

  typedef struct packed {
    logic [1:0]              row_index;
    logic signed [OutW-1:0]  col0;
    logic signed [OutW-1:0]  col1;
    logic signed [OutW-1:0]  col2;
    logic signed [OutW-1:0]  col3;
    logic                    last_row;
  } out_t;

  // Axis plus rounded sine and cosine at 2^-16, handed from front to back.
  typedef struct packed {
    logic signed [15:0]     ax;
    logic signed [15:0]     ay;
    logic signed [15:0]     az;
    logic signed [ScW-1:0]  s;
    logic signed [ScW-1:0]  c;
  } sc_t;

  function automatic logic signed [CordW-1:0] atan_q30(input int unsigned idx);
    logic signed [CordW-1:0] r;
    begin
      unique case (idx)
        0: r = 34'sh03243F6A8;
        1: r = 34'sh01DAC6705;
        2: r = 34'sh00FADBAFC;
        3: r = 34'sh007F56EA6;
        4: r = 34'sh003FEAB76;
        5: r = 34'sh001FFD55B;
        6: r = 34'sh000FFFAAA;
        7: r = 34'sh0007FFF55;
        8: r = 34'sh0003FFFEA;
        9: r = 34'sh0001FFFFD;
        10: r = 34'sh0000FFFFF;
        11: r = 34'sh00007FFFF;
        12: r = 34'sh00003FFFF;
        13: r = 34'sh00001FFFF;
        14: r = 34'sh00000FFFF;
        15: r = 34'sh000007FFF;
        16: r = 34'sh000003FFF;
        17: r = 34'sh000001FFF;
        18: r = 34'sh000000FFF;
        19: r = 34'sh0000007FF;
        20: r = 34'sh0000003FF;
        21: r = 34'sh0000001FF;
        22: r = 34'sh0000000FF;
        23: r = 34'sh00000007F;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage

>>> design/aarm_fifo.sv
// Small first-in first-out queue of beats of any packed type.
// Depends on nothing; used between front and back and for the results.
module aarm_fifo #(
  parameter int DEPTH = 2,
  parameter type T = logic,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  T              wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output T              rdata_o,
  output logic          empty_o,
  output logic [CW-1:0] count_o
);

  T                mem_q [DEPTH];
  logic [AW-1:0]   wptr_q, rptr_q;
  logic [CW-1:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> design/aarm_front.sv
// Front part: angle clamp, quadrant fold and a pipelined CORDIC, one step a stage.
// Depends on aarm_pkg; delivers axis, sine and cosine beats to the middle queue.
module aarm_front #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  aarm_pkg::in_t   in_i,
  output logic            full_o,
  output logic            q_push_o,
  output aarm_pkg::sc_t   q_data_o,
  input  logic            q_full_i
);

  localparam int W = aarm_pkg::CordW;
  localparam int N = CORDIC_STEPS;

  logic signed [W-1:0] x_q [N+1];
  logic signed [W-1:0] y_q [N+1];
  logic signed [W-1:0] z_q [N+1];
  logic                neg_q [N+1];
  logic                vld_q [N+1];
  logic signed [15:0]  ax_q [N+1];
  logic signed [15:0]  ay_q [N+1];
  logic signed [15:0]  az_q [N+1];

  logic                advance;
  logic signed [15:0]  ang_c;
  logic signed [W-1:0] z0;
  logic signed [W-1:0] z0_f;
  logic                neg0;
  logic signed [W-1:0] xf, yf, cr, sr;

  // The whole pipe moves together; it halts only when its head cannot leave.
  assign advance  = !vld_q[N] || !q_full_i;
  assign full_o   = !advance;
  assign q_push_o = vld_q[N];

  always_comb begin
    if (in_i.angle > 16'(aarm_pkg::AngleLimit)) begin
      ang_c = 16'(aarm_pkg::AngleLimit);
    end else if (in_i.angle < -16'sd25736) begin
      ang_c = -16'sd25736;
    end else begin
      ang_c = in_i.angle;
    end
    z0 = W'(ang_c) <<< 17;
    neg0 = 1'b0;
    z0_f = z0;
    if (z0 > aarm_pkg::HalfPiQ30) begin
      z0_f = z0 - aarm_pkg::PiQ30;
      neg0 = 1'b1;
    end else if (z0 < -aarm_pkg::HalfPiQ30) begin
      z0_f = z0 + aarm_pkg::PiQ30;
      neg0 = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (advance) begin
      vld_q[0] <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      x_q[0]   <= aarm_pkg::GainQ30;
      y_q[0]   <= '0;
      z_q[0]   <= z0_f;
      neg_q[0] <= neg0;
      ax_q[0]  <= in_i.axis_x;
      ay_q[0]  <= in_i.axis_y;
      az_q[0]  <= in_i.axis_z;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    localparam logic signed [W-1:0] Atan = aarm_pkg::atan_q30(i);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (advance) begin
        vld_q[i+1] <= vld_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (advance) begin
        if (!z_q[i][W-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - Atan;
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + Atan;
        end
        neg_q[i+1] <= neg_q[i];
        ax_q[i+1]  <= ax_q[i];
        ay_q[i+1]  <= ay_q[i];
        az_q[i+1]  <= az_q[i];
      end
    end
  end

  always_comb begin
    xf = neg_q[N] ? -x_q[N] : x_q[N];
    yf = neg_q[N] ? -y_q[N] : y_q[N];
    cr = (xf + W'(8192)) >>> 14;
    sr = (yf + W'(8192)) >>> 14;
    q_data_o.ax = ax_q[N];
    q_data_o.ay = ay_q[N];
    q_data_o.az = az_q[N];
    q_data_o.c  = cr[aarm_pkg::ScW-1:0];
    q_data_o.s  = sr[aarm_pkg::ScW-1:0];
  end

endmodule

>>> design/aarm_back.sv
// Back part: axis products once per item, then one matrix row per cycle while the result queue has room.
// Depends on aarm_pkg; reads the middle queue and fills the result queue.
module aarm_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  aarm_pkg::sc_t   q_data_i,
  output logic            q_pop_o,
  output logic            o_push_o,
  output aarm_pkg::out_t  o_data_o,
  input  logic [2:0]      o_count_i
);

  localparam int PW = 56;
  localparam int OW = aarm_pkg::OutW;
  localparam int SW = aarm_pkg::ScW;

  // Per-item products, held while the four rows go out.
  logic signed [31:0]   aa_q [3];
  logic signed [31:0]   ab_q [3];
  logic signed [35:0]   ks_q [3];
  logic signed [SW-1:0] c_q, omc_q;
  logic                 held_q;
  logic [1:0]           row_q;

  logic signed [PW-1:0] prod_q [3];
  logic signed [PW-1:0] add_q [3];
  logic                 bvld_q;
  logic [1:0]           brow_q;

  logic                 issue, finish, load;
  logic [3:0]           inflight;
  logic signed [32:0]   ma [3];
  logic signed [SW-1:0] mb [3];
  logic signed [PW-1:0] ad [3];
  logic signed [PW-1:0] rnd [3];

  assign inflight = {1'b0, o_count_i} + {3'b0, bvld_q};
  assign issue    = held_q && (inflight < 4'd4);
  assign finish   = issue && (row_q == aarm_pkg::LastRow);
  assign load     = !q_empty_i && (!held_q || finish);
  assign q_pop_o  = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
      row_q  <= '0;
      bvld_q <= 1'b0;
    end else begin
      bvld_q <= issue;
      if (load) begin
        held_q <= 1'b1;
        row_q  <= '0;
      end else if (finish) begin
        held_q <= 1'b0;
      end else if (issue) begin
        row_q <= row_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      aa_q[0] <= q_data_i.ax * q_data_i.ax;
      aa_q[1] <= q_data_i.ay * q_data_i.ay;
      aa_q[2] <= q_data_i.az * q_data_i.az;
      ab_q[0] <= q_data_i.ax * q_data_i.ay;
      ab_q[1] <= q_data_i.ax * q_data_i.az;
      ab_q[2] <= q_data_i.ay * q_data_i.az;
      ks_q[0] <= 36'(q_data_i.ax) * 36'(q_data_i.s);
      ks_q[1] <= 36'(q_data_i.ay) * 36'(q_data_i.s);
      ks_q[2] <= 36'(q_data_i.az) * 36'(q_data_i.s);
      c_q     <= q_data_i.c;
      omc_q   <= SW'(65536) - q_data_i.c;
    end
  end

  // Diagonal terms use c*(1 - aa) + aa; off-diagonal ones ab*(1 - c) +/- k*s.
  always_comb begin
    logic signed [32:0]   one_m_aa [3];
    logic signed [PW-1:0] aa_t [3];
    logic signed [PW-1:0] ks_t [3];
    for (int k = 0; k < 3; k++) begin
      one_m_aa[k] = 33'sd268435456 - 33'(aa_q[k]);
      aa_t[k] = PW'(aa_q[k]) <<< 16;
      ks_t[k] = PW'(ks_q[k]) <<< 14;
    end
    for (int j = 0; j < 3; j++) begin
      ma[j] = 33'(ab_q[0]);
      mb[j] = omc_q;
      ad[j] = '0;
    end
    unique case (row_q)
      2'd0: begin
        ma[0] = one_m_aa[0]; mb[0] = c_q; ad[0] = aa_t[0];
        ma[1] = 33'(ab_q[0]); ad[1] = -ks_t[2];
        ma[2] = 33'(ab_q[1]); ad[2] = ks_t[1];
      end
      2'd1: begin
        ma[0] = 33'(ab_q[0]); ad[0] = ks_t[2];
        ma[1] = one_m_aa[1]; mb[1] = c_q; ad[1] = aa_t[1];
        ma[2] = 33'(ab_q[2]); ad[2] = -ks_t[0];
      end
      2'd2: begin
        ma[0] = 33'(ab_q[1]); ad[0] = -ks_t[1];
        ma[1] = 33'(ab_q[2]); ad[1] = ks_t[0];
        ma[2] = one_m_aa[2]; mb[2] = c_q; ad[2] = aa_t[2];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      for (int j = 0; j < 3; j++) begin
        prod_q[j] <= PW'(ma[j]) * PW'(mb[j]);
        add_q[j]  <= ad[j];
      end
      brow_q <= row_q;
    end
  end

  always_comb begin
    logic lr;
    for (int j = 0; j < 3; j++) begin
      rnd[j] = prod_q[j] + add_q[j] + PW'(134217728);
    end
    lr = (brow_q == aarm_pkg::LastRow);
    o_push_o           = bvld_q;
    o_data_o.row_index = brow_q;
    o_data_o.col0      = lr ? '0 : rnd[0][OW+27:28];
    o_data_o.col1      = lr ? '0 : rnd[1][OW+27:28];
    o_data_o.col2      = lr ? '0 : rnd[2][OW+27:28];
    o_data_o.col3      = lr ? OW'(65536) : '0;
    o_data_o.last_row  = lr;
  end

endmodule

>>> design/axis_angle_rotation_matrix_top.sv
// Axis-angle to 4x4 rotation matrix: a beat pushed with the axis and angle comes
// back as four row beats, row 0 first, last_row set on row 3. The CORDIC runs as
// a pipeline of CORDIC_STEPS stages, so it takes a new beat while earlier ones are
// still in flight; the back part emits one row per cycle while the result queue
// has room. Depends on aarm_pkg, aarm_front, aarm_fifo and aarm_back.
module axis_angle_rotation_matrix_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  input  aarm_pkg::in_t   in_data_i,
  output logic            full,
  output logic            empty,
  input  logic            pop,
  output aarm_pkg::out_t  out_data_o
);

  logic           f_push, q_full, q_empty, q_pop, o_push;
  aarm_pkg::sc_t  f_data, q_data;
  aarm_pkg::out_t o_data;
  logic [1:0]     q_count;
  logic [2:0]     o_count;
  logic           o_full;

  aarm_front #(.CORDIC_STEPS(CORDIC_STEPS)) u_front (
    .clk_i, .rst_ni,
    .push_i(push), .in_i(in_data_i), .full_o(full),
    .q_push_o(f_push), .q_data_o(f_data), .q_full_i(q_full)
  );

  aarm_fifo #(.DEPTH(2), .T(aarm_pkg::sc_t)) u_midq (
    .clk_i, .rst_ni,
    .push_i(f_push), .wdata_i(f_data), .full_o(q_full),
    .pop_i(q_pop), .rdata_o(q_data), .empty_o(q_empty), .count_o(q_count)
  );

  aarm_back u_back (
    .clk_i, .rst_ni,
    .q_empty_i(q_empty), .q_data_i(q_data), .q_pop_o(q_pop),
    .o_push_o(o_push), .o_data_o(o_data), .o_count_i(o_count)
  );

  aarm_fifo #(.DEPTH(4), .T(aarm_pkg::out_t)) u_outq (
    .clk_i, .rst_ni,
    .push_i(o_push), .wdata_i(o_data), .full_o(o_full),
    .pop_i(pop), .rdata_o(out_data_o), .empty_o(empty), .count_o(o_count)
  );

  logic unused_status;
  assign unused_status = ^{q_count, o_full};

endmodule
